>>> sv/rco_pkg.sv
// rco_pkg: shared types, register indexes and helpers for the rectangle outline overlay.
// No dependencies; every other file of the block imports it.
`default_nettype none

package rco_pkg;

  localparam int COORD_MAX = 16;             // field width of coordinates and sizes
  localparam int BND_W     = COORD_MAX + 3;  // signed width of box bounds, holds -2^N .. 2^(N+1)-2 for N = COORD_MAX
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CFG_AW-1:0] REG_CORNER_X     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CORNER_Y     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SIDE_LENGTH  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BORDER_WIDTH = 3'd3;
  localparam logic [CFG_AW-1:0] REG_OUTLINE_RGB  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_INTERIOR_RGB = 3'd5;
  localparam logic [CFG_AW-1:0] REG_FILL_ON      = 3'd6;
  localparam logic [CFG_AW-1:0] REG_FRAME_DIMS   = 3'd7;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_NONE   = 8'h00;

  typedef logic signed [BND_W-1:0] coord_t;

  typedef struct packed {
    logic [COORD_MAX-1:0] pix_col;
    logic [COORD_MAX-1:0] pix_row;
    logic [7:0]           in_red;
    logic [7:0]           in_green;
    logic [7:0]           in_blue;
    logic [7:0]           in_alpha;
    logic                 has_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_item_t;

  typedef struct packed {
    logic [COORD_MAX-1:0] corner_x;
    logic [COORD_MAX-1:0] corner_y;
    logic [COORD_MAX-1:0] side_length;
    logic [COORD_MAX-1:0] border_width;
    logic [23:0]          outline_rgb;
    logic [23:0]          interior_rgb;
    logic                 fill_on;
    logic [31:0]          frame_dims;
  } cfg_t;

  // box bounds of one transaction, all half-open spans
  typedef struct packed {
    logic     act;   // box enabled and pixel inside the frame
    coord_t   x1;    // cx + sx
    coord_t   xl;    // cx + t
    coord_t   xr;    // cx + sx - t
    coord_t   yt;    // cy + t
    coord_t   y1;    // cy + sy
    coord_t   yb;    // cy + sy - t
    in_item_t pix;
  } bnd_t;

  // keep the low coordinate bits and zero-extend to the signed bound width
  function automatic coord_t coord_ext(input logic [COORD_MAX-1:0] v,
                                       input logic [COORD_MAX-1:0] mask);
    coord_ext = coord_t'({{(BND_W - COORD_MAX){1'b0}}, v & mask});
  endfunction

endpackage

`default_nettype wire

>>> sv/rco_cfg.sv
// rco_cfg: configuration register file of the overlay, write-only.
// Depends on rco_pkg.
`default_nettype none

module rco_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [rco_pkg::CFG_AW-1:0]  cfg_idx,
  input  wire logic [rco_pkg::CFG_DW-1:0]  cfg_wdata,
  output rco_pkg::cfg_t                    cfg
);
  import rco_pkg::*;

  cfg_t regs_r, regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_CORNER_X:     regs_nxt.corner_x     = cfg_wdata[COORD_MAX-1:0];
        REG_CORNER_Y:     regs_nxt.corner_y     = cfg_wdata[COORD_MAX-1:0];
        REG_SIDE_LENGTH:  regs_nxt.side_length  = cfg_wdata[COORD_MAX-1:0];
        REG_BORDER_WIDTH: regs_nxt.border_width = cfg_wdata[COORD_MAX-1:0];
        REG_OUTLINE_RGB:  regs_nxt.outline_rgb  = cfg_wdata[23:0];
        REG_INTERIOR_RGB: regs_nxt.interior_rgb = cfg_wdata[23:0];
        REG_FILL_ON:      regs_nxt.fill_on      = cfg_wdata[0];
        REG_FRAME_DIMS:   regs_nxt.frame_dims   = cfg_wdata[31:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg = regs_r;

endmodule

`default_nettype wire

>>> sv/rco_bounds.sv
// rco_bounds: first two pipeline stages, box enable and clipping, then band bounds.
// Depends on rco_pkg.
`default_nettype none

module rco_bounds #(
  parameter int COORD_BITS = rco_pkg::COORD_MAX
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rco_pkg::cfg_t cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rco_pkg::in_item_t in_data,
  output logic           bnd_valid,
  input  wire logic      bnd_ready,
  output rco_pkg::bnd_t  bnd
);
  import rco_pkg::*;

  localparam logic [COORD_MAX-1:0] CMASK = COORD_MAX'((1 << COORD_BITS) - 1);

  coord_t cx, cy, side, t, w, h, col, row;
  assign cx   = coord_ext(cfg.corner_x, CMASK);
  assign cy   = coord_ext(cfg.corner_y, CMASK);
  assign side = coord_ext(cfg.side_length, CMASK);
  assign t    = coord_ext(cfg.border_width, CMASK);
  assign w    = coord_ext(cfg.frame_dims[31:16], CMASK);
  assign h    = coord_ext(cfg.frame_dims[15:0], CMASK);
  assign col  = coord_ext(in_data.pix_col, CMASK);
  assign row  = coord_ext(in_data.pix_row, CMASK);

  // stage 1: enable and clipped sides
  logic     v1_r, ready1, ready2;
  logic     act1_r, act1_nxt;
  coord_t   sx1_r, sx1_nxt, sy1_r, sy1_nxt;
  in_item_t pix1_r;

  always_comb begin
    act1_nxt = (cx <= w) && (cy <= h) && (t <= (cx >>> 1)) && (col < w) && (row < h);
    sx1_nxt  = ((cx + side) > w) ? (w - cx - coord_t'(1)) : side;
    sy1_nxt  = ((cy + side) > h) ? (h - cy - coord_t'(1)) : side;
  end

  // stage 2: band edges
  logic v2_r;
  bnd_t bnd_r, bnd_nxt;

  always_comb begin
    bnd_nxt.act = act1_r;
    bnd_nxt.x1  = cx + sx1_r;
    bnd_nxt.xl  = cx + t;
    bnd_nxt.xr  = cx + sx1_r - t;
    bnd_nxt.yt  = cy + t;
    bnd_nxt.y1  = cy + sy1_r;
    bnd_nxt.yb  = cy + sy1_r - t;
    bnd_nxt.pix = pix1_r;
  end

  assign ready2   = !v2_r || bnd_ready;
  assign ready1   = !v1_r || ready2;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      act1_r <= act1_nxt;
      sx1_r  <= sx1_nxt;
      sy1_r  <= sy1_nxt;
      pix1_r <= in_data;
    end
    if (ready2 && v1_r) begin
      bnd_r <= bnd_nxt;
    end
  end

  assign bnd_valid = v2_r;
  assign bnd       = bnd_r;

  // clipped sides never drop below -1 while the box is live
  a_sx_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && act1_r) |-> (sx1_r >= -coord_t'(1) && sy1_r >= -coord_t'(1)))
    else $error("clipped side below -1");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !bnd_ready) |=> (v2_r && $stable(bnd_r)))
    else $error("bounds stage lost a stalled transaction");
  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && bnd_r.act) |-> (bnd_r.xl + bnd_r.xr == bnd_r.x1 + coord_ext(cfg.corner_x, CMASK)))
    else $error("left and right band edges inconsistent");

endmodule

`default_nettype wire

>>> sv/rco_paint.sv
// rco_paint: last two pipeline stages, band hit test then colour select into the output register.
// Depends on rco_pkg.
`default_nettype none

module rco_paint #(
  parameter int COORD_BITS = rco_pkg::COORD_MAX
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rco_pkg::cfg_t cfg,
  input  wire logic       bnd_valid,
  output logic            bnd_ready,
  input  wire rco_pkg::bnd_t bnd,
  output logic            out_valid,
  input  wire logic       out_ready,
  output rco_pkg::out_item_t out_data
);
  import rco_pkg::*;

  localparam logic [COORD_MAX-1:0] CMASK = COORD_MAX'((1 << COORD_BITS) - 1);

  coord_t cx, cy, col, row;
  assign cx  = coord_ext(cfg.corner_x, CMASK);
  assign cy  = coord_ext(cfg.corner_y, CMASK);
  assign col = coord_ext(bnd.pix.pix_col, CMASK);
  assign row = coord_ext(bnd.pix.pix_row, CMASK);

  // stage 3: hit test
  logic line_c, fill_c;
  logic cols_all, top, bot, mid, left, right;

  always_comb begin
    cols_all = (col >= cx) && (col < bnd.x1);
    top      = (row >= cy) && (row < bnd.yt);
    bot      = (row >= bnd.yb) && (row < bnd.y1);
    mid      = (row >= bnd.yt) && (row < bnd.yb);
    left     = (col >= cx) && (col < bnd.xl);
    right    = (col >= bnd.xr) && (col < bnd.x1);
    line_c   = bnd.act && ((cols_all && (top || bot)) || (mid && (left || right)));
    fill_c   = bnd.act && cfg.fill_on && cols_all && (row >= cy) && (row < bnd.y1);
  end

  logic     v3_r, vo_r, ready3, ready_o;
  logic     line3_r, fill3_r;
  in_item_t pix3_r;

  // stage 4: colour select
  out_item_t out_r, out_nxt;
  logic [23:0] rgb;
  logic        painted;

  always_comb begin
    painted = line3_r || fill3_r;
    rgb     = line3_r ? cfg.outline_rgb : cfg.interior_rgb;
    if (painted) begin
      out_nxt.out_red   = rgb[23:16];
      out_nxt.out_green = rgb[15:8];
      out_nxt.out_blue  = rgb[7:0];
      out_nxt.out_alpha = ALPHA_OPAQUE;
    end else begin
      out_nxt.out_red   = pix3_r.in_red;
      out_nxt.out_green = pix3_r.in_green;
      out_nxt.out_blue  = pix3_r.in_blue;
      out_nxt.out_alpha = pix3_r.in_alpha;
    end
    if (!pix3_r.has_alpha) out_nxt.out_alpha = ALPHA_NONE;
  end

  assign ready_o   = !vo_r || out_ready;
  assign ready3    = !v3_r || ready_o;
  assign bnd_ready = ready3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ready3)  v3_r <= bnd_valid;
      if (ready_o) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && bnd_valid) begin
      line3_r <= line_c;
      fill3_r <= fill_c;
      pix3_r  <= bnd.pix;
    end
    if (ready_o && v3_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

  a_idle_box: assert property (@(posedge clk) disable iff (!rst_n)
    (bnd_valid && !bnd.act) |-> (!line_c && !fill_c))
    else $error("paint hit while box inactive");
  a_line_color: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && ready_o && line3_r) |=>
      ({out_r.out_red, out_r.out_green, out_r.out_blue} == cfg.outline_rgb))
    else $error("outline pixel lost its colour");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && !out_ready) |=> (vo_r && $stable(out_r)))
    else $error("output register changed under stall");

endmodule

`default_nettype wire

>>> sv/rectangle_outline_overlay.sv
// rectangle_outline_overlay: paints a square outline, optionally filled, onto a pixel stream.
//
// Input channel in_valid/in_ready/in_data carries one pixel with its column and row;
// output channel out_valid/out_ready/out_data returns the same pixel, possibly repainted.
// The cfg_we/cfg_idx/cfg_wdata port writes the eight box registers, one per cycle,
// with no wait state; write them only while no transaction is in flight.
// Four register stages: clip stage, bound stage, hit-test stage, output register.
// out_valid rises once the pixel has passed all four register stages. Throughput is one
// pixel per cycle while out_ready is high; each stage holds its own valid bit, so bubbles
// collapse and a stalled output only backs up the stages behind it. in_ready drops only
// when all four stages are full and out_ready is low.
// Synchronous active-low reset clears the config registers to 0 (box empty, fill off)
// and the valid bits, which empties the pipeline; data registers are not reset.
// Depends on rco_pkg, rco_cfg, rco_bounds and rco_paint.
`default_nettype none

module rectangle_outline_overlay #(
  parameter int COORD_BITS = rco_pkg::COORD_MAX
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire rco_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rco_pkg::out_item_t               out_data,
  input  wire logic                        cfg_we,
  input  wire logic [rco_pkg::CFG_AW-1:0]  cfg_idx,
  input  wire logic [rco_pkg::CFG_DW-1:0]  cfg_wdata
);
  import rco_pkg::*;

  cfg_t cfg;
  bnd_t bnd;
  logic bnd_valid, bnd_ready;

  rco_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rco_bounds #(.COORD_BITS(COORD_BITS)) u_bounds (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .bnd_valid (bnd_valid),
    .bnd_ready (bnd_ready),
    .bnd       (bnd)
  );

  rco_paint #(.COORD_BITS(COORD_BITS)) u_paint (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .bnd_valid (bnd_valid),
    .bnd_ready (bnd_ready),
    .bnd       (bnd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
